// File: hw/rtl/ngga_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ngga_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned SAT_W  = 7;

   localparam logic [SAT_W-1:0]  SAT_MAX            = 7'd99;
   localparam logic [TIME_W-1:0] FIX_HOLD_RESET     = 32'd900000;
   localparam logic [TIME_W-1:0] SEARCH_LIMIT_RESET = 32'd3600000;
   localparam logic [SAT_W-1:0]  SAT_THRESH_RESET   = 7'd4;

   typedef enum logic [1:0] {
      CSR_FIX_HOLD     = 2'd0,
      CSR_SEARCH_LIMIT = 2'd1,
      CSR_SAT_THRESH   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_SEARCHING = 2'd0,
      STATUS_DONE      = 2'd1,
      STATUS_TIMEOUT   = 2'd2
   } status_type;

   typedef struct packed {
      logic [TIME_W-1:0] fix_hold_ms;
      logic [TIME_W-1:0] search_limit_ms;
      logic [SAT_W-1:0]  sat_threshold;
   } cfg_type;

   // a gga sentence that ended with enough fields
   typedef struct packed {
      logic             valid;
      logic [SAT_W-1:0] sats;
   } report_type;

   typedef struct packed {
      status_type       status;
      logic [SAT_W-1:0] sat_count;
      logic             sat_updated;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/ngga_line_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module ngga_line_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               parse_en,
   input  wire logic [7:0]         rx_byte,
   output ngga_pkg::report_type    report
);

   localparam logic [2:0] PREFIX_LEN  = 3'd6;
   localparam logic [3:0] DELIM_MAX   = 4'd15;
   localparam logic [3:0] SAT_FIELD   = 4'd7;
   localparam logic [3:0] MIN_DELIMS  = 4'd8;

   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_NL      = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_VTAB    = 8'h0B;
   localparam logic [7:0] CHAR_FF      = 8'h0C;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   typedef enum logic [1:0] {
      NUM_SKIP    = 2'd0,
      NUM_DIGITS  = 2'd1,
      NUM_STOPPED = 2'd2
   } num_phase_type;

   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0:    ch = 8'h24;  // $
         3'd1:    ch = 8'h47;  // G
         3'd2:    ch = 8'h50;  // P
         3'd3:    ch = 8'h47;  // G
         3'd4:    ch = 8'h47;  // G
         3'd5:    ch = 8'h41;  // A
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   logic [2:0]                 pos_ff, pos_in;
   logic                       match_ff, match_in;
   logic [3:0]                 delim_ff, delim_in;
   num_phase_type              phase_ff, phase_in;
   logic                       neg_ff, neg_in;
   logic [ngga_pkg::SAT_W-1:0] value_ff, value_in;

   logic                       is_delim, is_nl, is_digit, is_blank, is_sign;
   logic [9:0]                 acc_wide;
   logic [ngga_pkg::SAT_W-1:0] acc_sat;

   always_comb begin
      is_nl    = (rx_byte == CHAR_NL);
      is_delim = (rx_byte == CHAR_COMMA) || is_nl;
      is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
      is_blank = (rx_byte == CHAR_SPACE) || (rx_byte == CHAR_TAB) || (rx_byte == CHAR_VTAB)
              || (rx_byte == CHAR_FF) || (rx_byte == CHAR_CR);
      is_sign  = (rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS);
      // value*10 + digit, digit value sits in the low nibble of an ascii digit
      acc_wide = ({3'b000, value_ff} << 3) + ({3'b000, value_ff} << 1) + {6'b0, rx_byte[3:0]};
      acc_sat  = (acc_wide > {3'b000, ngga_pkg::SAT_MAX}) ? ngga_pkg::SAT_MAX : acc_wide[6:0];
   end

   always_comb begin
      pos_in   = pos_ff;
      match_in = match_ff;
      delim_in = delim_ff;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      value_in = value_ff;
      report   = '0;

      if (pos_ff < PREFIX_LEN) begin
         if (rx_byte != prefix_char(pos_ff)) begin
            match_in = 1'b0;
         end
         pos_in = pos_ff + 3'd1;
      end

      if (is_delim) begin
         if (delim_ff != DELIM_MAX) begin
            delim_in = delim_ff + 4'd1;
         end
      end else if (delim_ff == SAT_FIELD) begin
         unique case (phase_ff)
            NUM_SKIP: begin
               priority if (is_blank) begin
                  phase_in = NUM_SKIP;
               end else if (is_sign) begin
                  neg_in   = (rx_byte == CHAR_MINUS);
                  phase_in = NUM_DIGITS;
               end else if (is_digit) begin
                  phase_in = NUM_DIGITS;
                  value_in = acc_sat;
               end else begin
                  phase_in = NUM_STOPPED;
               end
            end
            NUM_DIGITS: begin
               if (is_digit) begin
                  value_in = acc_sat;
               end else begin
                  phase_in = NUM_STOPPED;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      if (is_nl) begin
         report.valid = parse_en && match_in && (pos_in >= PREFIX_LEN)
                     && (delim_in >= MIN_DELIMS);
         report.sats  = neg_in ? '0 : value_in;
         // newline starts a fresh line
         pos_in   = '0;
         match_in = 1'b1;
         delim_in = '0;
         phase_in = NUM_SKIP;
         neg_in   = 1'b0;
         value_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         match_ff <= 1'b1;
         delim_ff <= '0;
         phase_ff <= NUM_SKIP;
         neg_ff   <= 1'b0;
         value_ff <= '0;
      end else if (parse_en) begin
         pos_ff   <= pos_in;
         match_ff <= match_in;
         delim_ff <= delim_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         value_ff <= value_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ngga_fix_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

module ngga_fix_tracker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic                  action,
   input  wire ngga_pkg::cfg_type     cfg,
   input  wire ngga_pkg::report_type  report,
   output logic                       parse_en,
   output ngga_pkg::result_type       result
);

   localparam logic [ngga_pkg::TIME_W-1:0] TIME_MAX = '1;

   ngga_pkg::status_type              status_ff, status_in;
   logic [ngga_pkg::TIME_W-1:0]       elapsed_ff, elapsed_in;
   logic [ngga_pkg::TIME_W-1:0]       fix_start_ff, fix_start_in;
   logic                              fix_seen_ff, fix_seen_in;
   logic [ngga_pkg::SAT_W-1:0]        last_sats_ff, last_sats_in;

   logic                              searching;
   logic                              limit_hit;
   logic [ngga_pkg::TIME_W-1:0]       elapsed_inc;
   logic [ngga_pkg::TIME_W-1:0]       held_ms;

   always_comb begin
      searching   = (status_ff == ngga_pkg::STATUS_SEARCHING);
      limit_hit   = (elapsed_ff >= cfg.search_limit_ms);
      elapsed_inc = (elapsed_ff == TIME_MAX) ? elapsed_ff
                                             : elapsed_ff + ngga_pkg::TIME_W'(1);
      held_ms     = elapsed_ff - fix_start_ff;
      // a byte that finds the limit already reached is dropped
      parse_en    = step && searching && !action && !limit_hit;
   end

   always_comb begin
      status_in    = status_ff;
      elapsed_in   = elapsed_ff;
      fix_start_in = fix_start_ff;
      fix_seen_in  = fix_seen_ff;
      last_sats_in = last_sats_ff;

      if (searching) begin
         priority if (action) begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc >= cfg.search_limit_ms) begin
               status_in = ngga_pkg::STATUS_TIMEOUT;
            end
         end else if (limit_hit) begin
            status_in = ngga_pkg::STATUS_TIMEOUT;
         end else if (report.valid) begin
            last_sats_in = report.sats;
            if (report.sats > cfg.sat_threshold) begin
               if (!fix_seen_ff) begin
                  fix_seen_in  = 1'b1;
                  fix_start_in = elapsed_ff;
               end else if (held_ms >= cfg.fix_hold_ms) begin
                  status_in = ngga_pkg::STATUS_DONE;
               end
            end
         end else begin
            status_in = status_ff;
         end
      end

      result.status      = status_in;
      result.sat_count   = last_sats_in;
      result.sat_updated = report.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= ngga_pkg::STATUS_SEARCHING;
         elapsed_ff   <= '0;
         fix_start_ff <= '0;
         fix_seen_ff  <= 1'b0;
         last_sats_ff <= '0;
      end else if (step) begin
         status_ff    <= status_in;
         elapsed_ff   <= elapsed_in;
         fix_start_ff <= fix_start_in;
         fix_seen_ff  <= fix_seen_in;
         last_sats_ff <= last_sats_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/nmea_gga_satellite_fix_monitor.sv
`timescale 1ns / 1ps
`default_nettype none

// GGA satellite fix monitor. Each transaction on req_ is either one received
// NMEA byte or one millisecond tick, and yields exactly one rsp_ transaction
// with the search status, the latest reported satellite count and a flag for
// a GGA sentence that ended on this item. Throughput is one transaction per
// clock: an item goes through an input register, one pass of parse and
// timer logic, and a result register that drives rsp_, and the input side
// stalls only while the result register holds a response that rsp_ready
// has not taken. Registers on csr_ are to be written by the user only while
// no transaction is in flight; the block itself does not enforce this.
module nmea_gga_satellite_fix_monitor (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_action,
   input  wire logic [7:0]                     req_rx_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [ngga_pkg::SAT_W-1:0]          rsp_sat_count,
   output logic                                rsp_sat_updated,
   input  wire logic                           csr_we,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [ngga_pkg::TIME_W-1:0]    csr_wdata
);

   ngga_pkg::cfg_type     cfg_ff;
   logic                  in_valid_ff;
   logic                  in_action_ff;
   logic [7:0]            in_byte_ff;
   logic                  out_valid_ff;
   ngga_pkg::result_type  out_ff;

   logic                  advance;
   logic                  parse_en;
   ngga_pkg::report_type  report;
   ngga_pkg::result_type  result;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fix_hold_ms     <= ngga_pkg::FIX_HOLD_RESET;
         cfg_ff.search_limit_ms <= ngga_pkg::SEARCH_LIMIT_RESET;
         cfg_ff.sat_threshold   <= ngga_pkg::SAT_THRESH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ngga_pkg::CSR_FIX_HOLD:     cfg_ff.fix_hold_ms     <= csr_wdata;
            ngga_pkg::CSR_SEARCH_LIMIT: cfg_ff.search_limit_ms <= csr_wdata;
            ngga_pkg::CSR_SAT_THRESH:   cfg_ff.sat_threshold   <= csr_wdata[ngga_pkg::SAT_W-1:0];
            default:                    cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_rx_byte;
      end
   end

   ngga_line_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .parse_en (parse_en),
      .rx_byte  (in_byte_ff),
      .report   (report)
   );

   ngga_fix_tracker u_tracker (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .action   (in_action_ff),
      .cfg      (cfg_ff),
      .report   (report),
      .parse_en (parse_en),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_sat_count   = out_ff.sat_count;
   assign rsp_sat_updated = out_ff.sat_updated;

endmodule

`default_nettype wire

// File: hw/rtl/ngga_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ngga_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [1:0]  rsp_status,
   input  wire logic [6:0]  rsp_sat_count,
   input  wire logic        rsp_sat_updated
);

   logic       latched_ff;
   logic [1:0] held_status_ff;

   // remember the first final status that left the block
   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff     <= 1'b0;
         held_status_ff <= ngga_pkg::STATUS_SEARCHING;
      end else if (rsp_valid && rsp_ready && !latched_ff
                   && rsp_status != ngga_pkg::STATUS_SEARCHING) begin
         latched_ff     <= 1'b1;
         held_status_ff <= rsp_status;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_sat_count) && $stable(rsp_sat_updated))
      else $error("response changed while stalled");

   a_final_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && latched_ff |-> rsp_status == held_status_ff && !rsp_sat_updated)
      else $error("final status not held or sentence reported after it");

   a_no_report_on_timeout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ngga_pkg::STATUS_TIMEOUT |-> !rsp_sat_updated)
      else $error("sentence reported on a timed out transaction");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sat_count <= ngga_pkg::SAT_MAX
         && rsp_status != 2'd3)
      else $error("response field out of range");

endmodule

bind nmea_gga_satellite_fix_monitor ngga_checker u_ngga_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_sat_count   (rsp_sat_count),
   .rsp_sat_updated (rsp_sat_updated)
);

`default_nettype wire

// File: verif/gga_fix_compare.sv
`timescale 1ns / 1ps

module gga_fix_compare (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_action,
   input  logic [7:0]                  req_rx_byte,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [1:0]                  rsp_status,
   input  logic [ngga_pkg::SAT_W-1:0]  rsp_sat_count,
   input  logic                        rsp_sat_updated,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [ngga_pkg::TIME_W-1:0] csr_wdata,
   output int                          fail_count,
   output int                          results_waiting,
   output logic                        search_latched
);

   import ngga_pkg::*;

   localparam logic [47:0] GGA_PREFIX = "$GPGGA";
   localparam int          PREFIX_LEN = 6;
   localparam int          DELIM_MAX  = 15;
   localparam int          SATS_FIELD = 7;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [1:0] {
      NUM_SKIP   = 2'd0,
      NUM_DIGITS = 2'd1,
      NUM_DONE   = 2'd2
   } num_phase_type;

   logic [TIME_W-1:0] hold_ms;
   logic [TIME_W-1:0] limit_ms;
   logic [SAT_W-1:0]  thresh;

   int                line_pos;
   logic              prefix_ok;
   logic [3:0]        delims;
   num_phase_type     num_phase;
   logic              num_neg;
   logic [SAT_W-1:0]  num_val;
   logic              fix_seen;
   logic [TIME_W-1:0] elapsed_ms;
   logic [TIME_W-1:0] fix_start_ms;
   status_type        search_state;
   logic [SAT_W-1:0]  last_sats;

   result_type        fix_results_due[$];
   int                mismatches = 0;

   task automatic restart_line();
      line_pos  = 0;
      prefix_ok = 1'b1;
      delims    = '0;
      num_phase = NUM_SKIP;
      num_neg   = 1'b0;
      num_val   = '0;
   endtask

   task automatic advance_fix_search(input logic act, input logic [7:0] ch);
      result_type        due;
      logic              hit;
      logic              digit;
      logic [SAT_W-1:0]  sats;
      logic [TIME_W-1:0] held;
      int                acc;
      hit   = 1'b0;
      digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
      acc   = int'(num_val) * 10 + int'(ch) - int'(CH_ZERO);
      if (search_state == STATUS_SEARCHING) begin
         if (act) begin
            if (elapsed_ms != '1) elapsed_ms++;
            if (elapsed_ms >= limit_ms) search_state = STATUS_TIMEOUT;
         end else if (elapsed_ms >= limit_ms) begin
            // the byte that meets the limit is dropped unparsed
            search_state = STATUS_TIMEOUT;
         end else begin
            if (line_pos < PREFIX_LEN) begin
               if (ch != GGA_PREFIX[47 - 8 * line_pos -: 8]) prefix_ok = 1'b0;
               line_pos++;
            end
            if (ch == CH_COMMA || ch == CH_NL) begin
               if (delims < DELIM_MAX) delims++;
            end else if (delims == SATS_FIELD) begin
               case (num_phase)
                  NUM_SKIP: begin
                     if (ch == CH_SPACE || ch == CH_TAB || ch == CH_VT || ch == CH_FF ||
                         ch == CH_CR) begin
                        num_phase = NUM_SKIP;
                     end else if (ch == CH_PLUS || ch == CH_MINUS) begin
                        num_neg   = (ch == CH_MINUS);
                        num_phase = NUM_DIGITS;
                     end else if (digit) begin
                        num_phase = NUM_DIGITS;
                        num_val   = (acc > int'(SAT_MAX)) ? SAT_MAX : acc[SAT_W-1:0];
                     end else begin
                        num_phase = NUM_DONE;
                     end
                  end
                  NUM_DIGITS: begin
                     if (digit) begin
                        num_val = (acc > int'(SAT_MAX)) ? SAT_MAX : acc[SAT_W-1:0];
                     end else begin
                        num_phase = NUM_DONE;
                     end
                  end
                  default: ;
               endcase
            end
            if (ch == CH_NL) begin
               if (prefix_ok && line_pos >= PREFIX_LEN && delims >= 8) begin
                  sats      = num_neg ? '0 : num_val;
                  last_sats = sats;
                  hit       = 1'b1;
                  if (sats > thresh) begin
                     held = elapsed_ms - fix_start_ms;
                     if (!fix_seen) begin
                        fix_seen     = 1'b1;
                        fix_start_ms = elapsed_ms;
                     end else if (held >= hold_ms) begin
                        search_state = STATUS_DONE;
                     end
                  end
               end
               restart_line();
            end
         end
      end
      due.status      = search_state;
      due.sat_count   = last_sats;
      due.sat_updated = hit;
      fix_results_due.push_back(due);
   endtask

   always @(posedge clock) begin : compare_step
      result_type due;
      if (reset) begin
         hold_ms      = FIX_HOLD_RESET;
         limit_ms     = SEARCH_LIMIT_RESET;
         thresh       = SAT_THRESH_RESET;
         restart_line();
         fix_seen     = 1'b0;
         elapsed_ms   = '0;
         fix_start_ms = '0;
         search_state = STATUS_SEARCHING;
         last_sats    = '0;
         fix_results_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_FIX_HOLD:     hold_ms  = csr_wdata;
               CSR_SEARCH_LIMIT: limit_ms = csr_wdata;
               CSR_SAT_THRESH:   thresh   = csr_wdata[SAT_W-1:0];
               default: ;
            endcase
         end
         // responses are checked before this edge's request is predicted
         if (rsp_valid && rsp_ready) begin
            if (fix_results_due.size() == 0) begin
               $error("rsp transaction with nothing pending: status %0d sat_count %0d",
                      rsp_status, rsp_sat_count);
               mismatches++;
            end else begin
               due = fix_results_due.pop_front();
               if (rsp_status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_status);
                  mismatches++;
               end
               if (rsp_sat_count !== due.sat_count) begin
                  $error("sat_count: expected %0d, got %0d", due.sat_count, rsp_sat_count);
                  mismatches++;
               end
               if (rsp_sat_updated !== due.sat_updated) begin
                  $error("sat_updated: expected %0d, got %0d", due.sat_updated,
                         rsp_sat_updated);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) advance_fix_search(req_action, req_rx_byte);
      end
      fail_count      <= mismatches;
      results_waiting <= fix_results_due.size();
      search_latched  <= (search_state != STATUS_SEARCHING);
   end

endmodule

// File: verif/nmea_gga_satellite_fix_monitor_tb.sv
`timescale 1ns / 1ps

module nmea_gga_satellite_fix_monitor_tb;

   import ngga_pkg::*;

   localparam int RANDOM_ITEMS   = 950;
   localparam int LONG_STALL     = 300;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   typedef enum int {
      END_FIX_HELD,
      END_TICK_TIMEOUT,
      END_ZERO_LIMIT
   } search_end_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_action;
   logic [7:0]          req_rx_byte;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [1:0]          rsp_status;
   logic [SAT_W-1:0]    rsp_sat_count;
   logic                rsp_sat_updated;
   logic                csr_we;
   logic [1:0]          csr_index;
   logic [TIME_W-1:0]   csr_wdata;

   int                  fail_count;
   int                  results_waiting;
   logic                search_latched;

   logic                quiet = 1'b0;
   logic                sender_gaps = 1'b0;
   logic                long_stall_done = 1'b0;
   int unsigned         ticks_sent = 0;
   int                  items_sent = 0;
   int                  rsp_taken = 0;

   logic [7:0]          line_buf[$];
   string               gga_tag = "$GPGGA";
   string               field_chars = "0123456789.NSEWM";

   always #4 clock = ~clock;

   nmea_gga_satellite_fix_monitor DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_sat_count   (rsp_sat_count),
      .rsp_sat_updated (rsp_sat_updated),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   gga_fix_compare u_compare (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_sat_count   (rsp_sat_count),
      .rsp_sat_updated (rsp_sat_updated),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .results_waiting (results_waiting),
      .search_latched  (search_latched)
   );

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) rsp_taken <= rsp_taken + 1;
   end

   task automatic push_item(input logic act, input logic [7:0] ch);
      if (sender_gaps && !quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_rx_byte <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (act) ticks_sent++;
      items_sent++;
   endtask

   task automatic push_ticks(input int count);
      repeat (count) push_item(1'b1, 8'($urandom_range(0, 255)));
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic put_field();
      repeat ($urandom_range(0, 3))
         line_buf.push_back(field_chars[$urandom_range(0, field_chars.len() - 1)]);
   endtask

   // prefix and the six fields ahead of the satellite count
   task automatic put_gga_head();
      put_text(gga_tag);
      repeat (6) begin
         line_buf.push_back(CH_COMMA);
         put_field();
      end
      line_buf.push_back(CH_COMMA);
   endtask

   // the blanks that the number reader skips
   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 4))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_VT;
         3:       return CH_FF;
         default: return CH_CR;
      endcase
   endfunction

   task automatic put_sats_text();
      int v;
      v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 999) : $urandom_range(0, 20);
      case ($urandom_range(0, 9))
         0: ;
         1: begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(blank_char());
            put_text($sformatf("%0d", v));
         end
         2: begin
            line_buf.push_back(CH_PLUS);
            put_text($sformatf("%0d", v));
         end
         3: begin
            line_buf.push_back(CH_MINUS);
            put_text($sformatf("%0d", v));
         end
         4: begin
            // a blank right after the sign ends the number
            line_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            line_buf.push_back(blank_char());
            put_text($sformatf("%0d", v));
         end
         5: begin
            // a sign or dot after digits stops parsing
            put_text($sformatf("%0d", v));
            line_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_DOT);
            put_text($sformatf("%0d", $urandom_range(0, 9)));
         end
         6: begin
            line_buf.push_back(CH_NUL);
            put_text($sformatf("%0d", v));
         end
         7: put_text($sformatf("0%0d", v));
         8: begin
            put_text("+-");
            put_text($sformatf("%0d", v));
         end
         default: put_text($sformatf("%0d", v));
      endcase
   endtask

   task automatic build_random_line();
      int kind;
      int n;
      int spot;
      kind = $urandom_range(0, 15);
      if (kind <= 10) begin
         put_gga_head();
         put_sats_text();
         // sometimes enough extra fields to saturate the delimiter count
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 4);
         repeat (n) begin
            line_buf.push_back(CH_COMMA);
            put_field();
         end
         if ($urandom_range(0, 1)) line_buf.push_back(CH_CR);
         line_buf.push_back(CH_NL);
      end else if (kind == 11) begin
         put_gga_head();
         spot = $urandom_range(0, 5);
         line_buf[spot] = 8'($urandom_range(0, 255));
         put_sats_text();
         line_buf.push_back(CH_NL);
      end else if (kind == 12) begin
         // newline before the prefix is complete
         n = $urandom_range(0, 5);
         for (int i = 0; i < n; i++) line_buf.push_back(gga_tag[i]);
         line_buf.push_back(CH_NL);
      end else if (kind == 13) begin
         put_text(gga_tag);
         repeat ($urandom_range(0, 6)) begin
            line_buf.push_back(CH_COMMA);
            put_field();
         end
         line_buf.push_back(CH_NL);
      end else begin
         repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1)) line_buf.push_back(CH_NL);
      end
   endtask

   task automatic flush_line(input int tick_pct);
      foreach (line_buf[i]) begin
         if ($urandom_range(0, 99) < tick_pct) push_item(1'b1, 8'($urandom_range(0, 255)));
         push_item(1'b0, line_buf[i]);
      end
      line_buf.delete();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (results_waiting != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_search(input logic [TIME_W-1:0] hold, input logic [TIME_W-1:0] limit,
                                 input logic [SAT_W-1:0] thresh);
      csr_we    <= 1'b1;
      csr_index <= CSR_FIX_HOLD;
      csr_wdata <= hold;
      @(posedge clock);
      csr_index <= CSR_SEARCH_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_index <= CSR_SAT_THRESH;
      csr_wdata <= TIME_W'(thresh);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // receiver side: random stalls, one long hold-off, none at the end
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (quiet) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if (!long_stall_done && rsp_taken >= 150 && req_valid) begin
            long_stall_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   initial begin
      int idle_run;
      idle_run = 0;
      while (idle_run < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
            idle_run = 0;
         end else begin
            idle_run++;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [TIME_W-1:0] hold;
      logic [TIME_W-1:0] limit;
      logic [SAT_W-1:0]  thresh;
      int                tick_pct;
      int                guard;
      search_end_type    ending;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_action  <= 1'b0;
      req_rx_byte <= 8'h00;
      csr_we      <= 1'b0;
      csr_index   <= CSR_FIX_HOLD;
      csr_wdata   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: byte extremes on a short line, then a qualifying sentence
      push_item(1'b1, 8'hFF);
      push_item(1'b0, 8'hFF);
      push_item(1'b0, 8'h00);
      push_item(1'b0, CH_NL);
      put_text("$GPGGA,,,,,,, +9");
      line_buf.push_back(CH_NL);
      flush_line(0);

      while (items_sent < RANDOM_ITEMS) begin
         wait_drained();
         case ($urandom_range(0, 2))
            0:       hold = FIX_HOLD_RESET;
            1:       hold = '1;
            default: hold = $urandom_range(32'h0010_0000, 32'hFFFF_FFFF);
         endcase
         case ($urandom_range(0, 2))
            0:       limit = SEARCH_LIMIT_RESET;
            1:       limit = '1;
            default: limit = $urandom_range(32'h0010_0000, 32'hFFFF_FFFF);
         endcase
         case ($urandom_range(0, 5))
            0:       thresh = '0;
            1:       thresh = SAT_MAX;
            2:       thresh = '1;
            3:       thresh = SAT_W'($urandom_range(100, 127));
            4:       thresh = SAT_W'($urandom_range(0, 127));
            default: thresh = SAT_W'($urandom_range(0, 12));
         endcase
         program_search(hold, limit, thresh);
         sender_gaps = ($urandom_range(0, 3) != 0);
         tick_pct    = $urandom_range(0, 20);
         repeat ($urandom_range(4, 8)) begin
            build_random_line();
            flush_line(tick_pct);
            push_ticks($urandom_range(0, 3));
         end
      end

      wait_drained();
      quiet       = 1'b1;
      sender_gaps = 1'b0;
      ending      = search_end_type'($urandom_range(0, 2));
      guard       = 0;
      case (ending)
         END_FIX_HELD: begin
            hold = ($urandom_range(0, 3) == 0) ? '0 : TIME_W'($urandom_range(1, 40));
            program_search(hold, '1, SAT_THRESH_RESET);
            while (!search_latched && guard < 400) begin
               put_gga_head();
               put_text("12");
               line_buf.push_back(CH_NL);
               flush_line(0);
               push_ticks($urandom_range(1, 12));
               guard++;
            end
         end
         END_TICK_TIMEOUT: begin
            program_search('1, TIME_W'(ticks_sent + $urandom_range(1, 30)),
                           SAT_W'($urandom_range(0, 127)));
            while (!search_latched && guard < 400) begin
               build_random_line();
               flush_line(30);
               push_ticks($urandom_range(0, 3));
               guard++;
            end
         end
         default: begin
            // a zero limit times out on the next byte before it is parsed
            program_search('1, '0, SAT_THRESH_RESET);
            push_item(1'b0, gga_tag[0]);
         end
      endcase

      // once latched, sentences and ticks are ignored
      put_gga_head();
      put_text("12");
      line_buf.push_back(CH_NL);
      flush_line(50);

      wait_drained();
      repeat (6) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
